// File: hw/rtl/nmea0183_to_can_converter_unit_assert.svh
// Assertion macros for the converter's top-level RTL file.
`ifndef NMEA0183_TO_CAN_CONVERTER_UNIT_ASSERT_SVH
`define NMEA0183_TO_CAN_CONVERTER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define N2C_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("n2c assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define N2C_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("n2c assertion failed");

`endif

// File: hw/rtl/n2c_pkg.sv
// Types, constants and constant functions of the NMEA 0183 to CAN converter.
`default_nettype none

package n2c_pkg;

    localparam int FIELD_BUFFER_BYTES   = 16;
    localparam int FRACTION_DIGITS_KEPT = 4;

    localparam int CHAR_W      = 8;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 8;
    localparam int PRIO_W      = 3;
    localparam int ADDR_W      = 8;
    localparam int PGN_W       = 18;
    localparam int ID_W        = 29;
    localparam int DLC_W       = 4;
    localparam int PAYLOAD_W   = 64;
    localparam int STATUS_W    = 2;
    localparam int CHAR_IDX_W  = 3;
    localparam int TYPE_W      = 24;
    localparam int COMMA_W     = 2;

    localparam int FL_W  = $clog2(FIELD_BUFFER_BYTES);
    localparam int FD_W  = $clog2(FRACTION_DIGITS_KEPT + 1);
    localparam int MAG_W = 47;
    localparam int ACC_W = MAG_W + 4;

    localparam logic [MAG_W-1:0] MAG_MAX    = '1;
    localparam logic [FL_W-1:0]  FIELD_LAST = FL_W'(FIELD_BUFFER_BYTES - 1);
    localparam logic [FD_W-1:0]  FD_KEPT    = FD_W'(FRACTION_DIGITS_KEPT);

    localparam logic [CHAR_W-1:0] CHAR_NUL    = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_DOLLAR = 8'h24;
    localparam logic [CHAR_W-1:0] CHAR_STAR   = 8'h2A;
    localparam logic [CHAR_W-1:0] CHAR_PLUS   = 8'h2B;
    localparam logic [CHAR_W-1:0] CHAR_COMMA  = 8'h2C;
    localparam logic [CHAR_W-1:0] CHAR_MINUS  = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_POINT  = 8'h2E;
    localparam logic [CHAR_W-1:0] CHAR_ZERO   = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE   = 8'h39;

    localparam logic [TYPE_W-1:0] TYPE_HDT = 24'h484454;
    localparam logic [TYPE_W-1:0] TYPE_DPT = 24'h445054;

    localparam logic [PGN_W-1:0] PGN_HEADING = 18'd127250;
    localparam logic [PGN_W-1:0] PGN_DEPTH   = 18'd128267;

    localparam logic [PRIO_W-1:0] PRIO_RESET = 3'd6;
    localparam logic [ADDR_W-1:0] ADDR_RESET = 8'hFF;
    localparam logic [DLC_W-1:0]  DLC_FRAME  = 4'd8;

    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_PRIORITY = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SOURCE_ADDRESS = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK        = 2'd0,
        STATUS_NO_DOLLAR = 2'd1,
        STATUS_NO_FIELD  = 2'd2
    } status_t;

    typedef struct packed {
        status_t status;
        logic    heading;
        logic    negative;
    } frame_info_t;

    function automatic longint unsigned pow10(input int unsigned n);
        longint unsigned p;
        p = 1;
        for (int i = 0; i < 19; i++) begin
            if (32'(i) < n) begin
                p = p * 10;
            end
        end
        return p;
    endfunction

    localparam logic [127:0] SCALE = 128'(pow10(FRACTION_DIGITS_KEPT));
    localparam int POW_W  = $clog2(SCALE + 1);
    localparam int PROD_W = MAG_W + POW_W;

    typedef logic [FRACTION_DIGITS_KEPT:0][POW_W-1:0] pad_table_t;

    function automatic pad_table_t make_pad_table();
        pad_table_t t;
        for (int i = 0; i <= FRACTION_DIGITS_KEPT; i++) begin
            t[i] = POW_W'(pow10(32'(FRACTION_DIGITS_KEPT - i)));
        end
        return t;
    endfunction

    localparam pad_table_t PAD_TABLE = make_pad_table();

    // Heading: floor(m * 10^(8-K) / 572958) by a reciprocal that is exact below the limit.
    localparam logic [127:0] HDT_LIMIT = 128'd400 * SCALE;
    localparam logic [127:0] HDT_NUM   = 128'(pow10(32'(8 - FRACTION_DIGITS_KEPT)));
    localparam logic [127:0] HDT_DEN   = 128'd572958;
    localparam int HM_W = $clog2(HDT_LIMIT + 1);
    localparam int HS   = HM_W + $clog2(HDT_DEN);
    localparam logic [127:0] HR = ((HDT_NUM << HS) + HDT_DEN - 1) / HDT_DEN;
    localparam int HR_W = $clog2(HR + 1);
    localparam int HP_W = HM_W + HR_W;
    localparam int HQ_W = HP_W - HS;
    localparam logic [31:0] HEADING_SAT = 32'h0000_FFFF;

    // Depth: floor(m * 100 / 10^K), saturating once the result needs more than 32 bits.
    localparam logic [127:0] DLIM = (((128'd1 << 32) * SCALE) + 128'd99) / 128'd100;
    localparam int DM_W  = $clog2(DLIM);
    localparam int DS    = DM_W + $clog2(SCALE);
    localparam logic [127:0] DR = ((128'd100 << DS) + SCALE - 1) / SCALE;
    localparam int DR_W  = $clog2(DR + 1);
    localparam int DLO_W = (DM_W + 1) / 2;
    localparam int DHI_W = DM_W - DLO_W;
    localparam int DLP_W = DLO_W + DR_W;
    localparam int DHP_W = DHI_W + DR_W;
    localparam int DP_W  = DM_W + DR_W;
    localparam int DQ_W  = DP_W - DS;

endpackage

`default_nettype wire

// File: hw/rtl/nmea0183_to_can_converter_unit.sv
// Top level of the NMEA 0183 sentence to CAN frame converter.
// One character is taken per cycle with no gaps, as long as results are taken.
// The result path is four registers deep: snapshot, scaling, division products, output.
// Synchronous active-low reset clears sentence state and pipeline valids; config regs get defaults.
`default_nettype none

`include "nmea0183_to_can_converter_unit_assert.svh"

module nmea0183_to_can_converter_unit (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [n2c_pkg::CHAR_W-1:0]        s_text_char,
    input  wire logic                              s_sentence_end,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [n2c_pkg::STATUS_W-1:0]           m_status,
    output logic [n2c_pkg::ID_W-1:0]               m_can_identifier,
    output logic [n2c_pkg::DLC_W-1:0]              m_data_length,
    output logic [n2c_pkg::PAYLOAD_W-1:0]          m_payload,
    input  wire logic                              cfg_wr_en,
    input  wire logic [n2c_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [n2c_pkg::CFG_DATA_W-1:0]    cfg_wr_data
);
    import n2c_pkg::*;

    logic [PRIO_W-1:0] frame_priority_reg;
    logic [ADDR_W-1:0] source_address_reg;

    logic [CHAR_IDX_W-1:0] char_index_reg, char_index_next;
    logic [TYPE_W-1:0]     type_letters_reg, type_letters_next;
    logic                  type_closed_reg, type_closed_next;
    logic [COMMA_W-1:0]    comma_count_reg, comma_count_next;
    logic [FL_W-1:0]       field_length_reg, field_length_next;
    logic                  field_closed_reg, field_closed_next;
    logic [MAG_W-1:0]      scaled_value_reg, scaled_value_next;
    logic [FD_W-1:0]       fraction_digits_reg, fraction_digits_next;
    logic                  seen_point_reg, seen_point_next;
    logic                  value_negative_reg, value_negative_next;
    logic                  number_stopped_reg, number_stopped_next;
    logic                  text_terminated_reg, text_terminated_next;
    logic                  start_bad_reg, start_bad_next;

    logic              in_accept;
    logic              is_digit;
    logic [ACC_W-1:0]  acc_sum;
    logic [MAG_W-1:0]  acc_value;
    frame_info_t       snap_info;

    logic              p1_valid_reg, p2_valid_reg, p3_valid_reg;
    logic              p1_ready, p2_ready, p3_ready, out_ready;
    frame_info_t       p1_info_reg, p2_info_reg, p3_info_reg;
    logic [MAG_W-1:0]  p1_value_reg;
    logic [FD_W-1:0]   p1_fd_reg;
    logic [PROD_W-1:0] pad_prod;
    logic [MAG_W-1:0]  p2_mag_reg;
    logic              p3_hdt_sat_reg, p3_dep_sat_reg;
    logic [HP_W-1:0]   p3_hprod_reg;
    logic [DLP_W-1:0]  p3_dlo_reg;
    logic [DHP_W-1:0]  p3_dhi_reg;

    logic [DP_W-1:0]   depth_sum;
    logic [HQ_W-1:0]   heading_q;
    logic [DQ_W-1:0]   depth_q;
    logic [15:0]       heading_field;
    logic [31:0]       depth_field;

    logic                 m_valid_reg;
    status_t              m_status_reg, m_status_next;
    logic [ID_W-1:0]      m_id_reg, m_id_next;
    logic [DLC_W-1:0]     m_dlc_reg, m_dlc_next;
    logic [PAYLOAD_W-1:0] m_payload_reg, m_payload_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_priority_reg <= PRIO_RESET;
            source_address_reg <= ADDR_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_FRAME_PRIORITY: frame_priority_reg <= cfg_wr_data[PRIO_W-1:0];
                CFG_SOURCE_ADDRESS: source_address_reg <= cfg_wr_data[ADDR_W-1:0];
                default: ;
            endcase
        end
    end

    assign out_ready = !m_valid_reg || m_ready;
    assign p3_ready  = !p3_valid_reg || out_ready;
    assign p2_ready  = !p2_valid_reg || p3_ready;
    assign p1_ready  = !p1_valid_reg || p2_ready;
    assign s_ready   = p1_ready;
    assign in_accept = s_valid && p1_ready;

    assign is_digit  = (s_text_char >= CHAR_ZERO) && (s_text_char <= CHAR_NINE);
    assign acc_sum   = ACC_W'({scaled_value_reg, 3'b000}) + ACC_W'({scaled_value_reg, 1'b0})
                     + ACC_W'(s_text_char[3:0]);
    assign acc_value = (acc_sum > ACC_W'(MAG_MAX)) ? MAG_MAX : acc_sum[MAG_W-1:0];

    always_comb begin
        char_index_next      = char_index_reg;
        type_letters_next    = type_letters_reg;
        type_closed_next     = type_closed_reg;
        comma_count_next     = comma_count_reg;
        field_length_next    = field_length_reg;
        field_closed_next    = field_closed_reg;
        scaled_value_next    = scaled_value_reg;
        fraction_digits_next = fraction_digits_reg;
        seen_point_next      = seen_point_reg;
        value_negative_next  = value_negative_reg;
        number_stopped_next  = number_stopped_reg;
        text_terminated_next = text_terminated_reg;
        start_bad_next       = start_bad_reg;
        if (!text_terminated_reg) begin
            if (char_index_reg == '0) begin
                start_bad_next = (s_text_char != CHAR_DOLLAR);
            end
            if (s_text_char == CHAR_NUL) begin
                text_terminated_next = 1'b1;
            end else begin
                if (char_index_reg >= 3'd3 && char_index_reg <= 3'd5 && !type_closed_reg) begin
                    if (s_text_char == CHAR_COMMA) begin
                        type_closed_next = 1'b1;
                    end else begin
                        case (char_index_reg)
                            3'd3:    type_letters_next[23:16] = type_letters_reg[23:16] | s_text_char;
                            3'd4:    type_letters_next[15:8]  = type_letters_reg[15:8]  | s_text_char;
                            default: type_letters_next[7:0]   = type_letters_reg[7:0]   | s_text_char;
                        endcase
                    end
                end
                if (comma_count_reg == 2'd1 && !field_closed_reg) begin
                    if (s_text_char == CHAR_COMMA || s_text_char == CHAR_STAR) begin
                        field_closed_next = 1'b1;
                    end else if (field_length_reg < FIELD_LAST) begin
                        field_length_next = field_length_reg + 1'b1;
                        if (!number_stopped_reg) begin
                            if (field_length_reg == '0 &&
                                (s_text_char == CHAR_PLUS || s_text_char == CHAR_MINUS)) begin
                                value_negative_next = (s_text_char == CHAR_MINUS);
                            end else if (is_digit) begin
                                if (!seen_point_reg) begin
                                    scaled_value_next = acc_value;
                                end else if (fraction_digits_reg < FD_KEPT) begin
                                    scaled_value_next    = acc_value;
                                    fraction_digits_next = fraction_digits_reg + 1'b1;
                                end
                            end else if (s_text_char == CHAR_POINT && !seen_point_reg) begin
                                seen_point_next = 1'b1;
                            end else begin
                                number_stopped_next = 1'b1;
                            end
                        end
                    end
                end
                if (s_text_char == CHAR_COMMA && comma_count_reg != '1) begin
                    comma_count_next = comma_count_reg + 1'b1;
                end
                if (char_index_reg != '1) begin
                    char_index_next = char_index_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (in_accept && s_sentence_end)) begin
            char_index_reg      <= '0;
            type_letters_reg    <= '0;
            type_closed_reg     <= 1'b0;
            comma_count_reg     <= '0;
            field_length_reg    <= '0;
            field_closed_reg    <= 1'b0;
            scaled_value_reg    <= '0;
            fraction_digits_reg <= '0;
            seen_point_reg      <= 1'b0;
            value_negative_reg  <= 1'b0;
            number_stopped_reg  <= 1'b0;
            text_terminated_reg <= 1'b0;
            start_bad_reg       <= 1'b0;
        end else if (in_accept) begin
            char_index_reg      <= char_index_next;
            type_letters_reg    <= type_letters_next;
            type_closed_reg     <= type_closed_next;
            comma_count_reg     <= comma_count_next;
            field_length_reg    <= field_length_next;
            field_closed_reg    <= field_closed_next;
            scaled_value_reg    <= scaled_value_next;
            fraction_digits_reg <= fraction_digits_next;
            seen_point_reg      <= seen_point_next;
            value_negative_reg  <= value_negative_next;
            number_stopped_reg  <= number_stopped_next;
            text_terminated_reg <= text_terminated_next;
            start_bad_reg       <= start_bad_next;
        end
    end

    always_comb begin
        snap_info.negative = value_negative_next;
        snap_info.heading  = 1'b0;
        if (start_bad_next) begin
            snap_info.status = STATUS_NO_DOLLAR;
        end else if (comma_count_next != '0 && type_letters_next == TYPE_HDT) begin
            snap_info.status  = STATUS_OK;
            snap_info.heading = 1'b1;
        end else if (comma_count_next != '0 && type_letters_next == TYPE_DPT) begin
            snap_info.status = STATUS_OK;
        end else begin
            snap_info.status = STATUS_NO_FIELD;
        end
    end

    assign pad_prod = PROD_W'(p1_value_reg) * PROD_W'(PAD_TABLE[p1_fd_reg]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
        end else begin
            if (p1_ready) begin
                p1_valid_reg <= in_accept && s_sentence_end;
            end
            if (p2_ready) begin
                p2_valid_reg <= p1_valid_reg;
            end
            if (p3_ready) begin
                p3_valid_reg <= p2_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (p1_ready) begin
            p1_info_reg  <= snap_info;
            p1_value_reg <= scaled_value_next;
            p1_fd_reg    <= fraction_digits_next;
        end
        if (p2_ready) begin
            p2_info_reg <= p1_info_reg;
            p2_mag_reg  <= (pad_prod > PROD_W'(MAG_MAX)) ? MAG_MAX : pad_prod[MAG_W-1:0];
        end
        if (p3_ready) begin
            p3_info_reg    <= p2_info_reg;
            p3_hdt_sat_reg <= p2_mag_reg > MAG_W'(HDT_LIMIT);
            p3_dep_sat_reg <= p2_mag_reg >= MAG_W'(DLIM);
            p3_hprod_reg   <= HP_W'(p2_mag_reg[HM_W-1:0]) * HP_W'(HR);
            p3_dlo_reg     <= DLP_W'(p2_mag_reg[DLO_W-1:0]) * DLP_W'(DR);
            p3_dhi_reg     <= DHP_W'(p2_mag_reg[DM_W-1:DLO_W]) * DHP_W'(DR);
        end
    end

    assign heading_q = p3_hprod_reg[HP_W-1:HS];
    assign depth_sum = DP_W'(p3_dlo_reg) + (DP_W'(p3_dhi_reg) << DLO_W);
    assign depth_q   = depth_sum[DP_W-1:DS];

    always_comb begin
        if (p3_info_reg.negative) begin
            heading_field = '0;
        end else if (p3_hdt_sat_reg || 32'(heading_q) > HEADING_SAT) begin
            heading_field = '1;
        end else begin
            heading_field = heading_q[15:0];
        end
        if (p3_info_reg.negative) begin
            depth_field = '0;
        end else if (p3_dep_sat_reg) begin
            depth_field = '1;
        end else begin
            depth_field = 32'(depth_q);
        end
        m_status_next = p3_info_reg.status;
        if (p3_info_reg.status != STATUS_OK) begin
            m_id_next      = '0;
            m_dlc_next     = '0;
            m_payload_next = '0;
        end else if (p3_info_reg.heading) begin
            m_id_next      = {frame_priority_reg, PGN_HEADING, source_address_reg};
            m_dlc_next     = DLC_FRAME;
            m_payload_next = {8'h00, 32'hFFFF_FFFF, heading_field, 8'hFF};
        end else begin
            m_id_next      = {frame_priority_reg, PGN_DEPTH, source_address_reg};
            m_dlc_next     = DLC_FRAME;
            m_payload_next = {24'hFF_FFFF, depth_field, 8'hFF};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_ready) begin
            m_valid_reg <= p3_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ready) begin
            m_status_reg  <= m_status_next;
            m_id_reg      <= m_id_next;
            m_dlc_reg     <= m_dlc_next;
            m_payload_reg <= m_payload_next;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_status         = m_status_reg;
    assign m_can_identifier = m_id_reg;
    assign m_data_length    = m_dlc_reg;
    assign m_payload        = m_payload_reg;

    `N2C_ASSERT_SAME(a_error_frame_empty, aclk, aresetn,
        m_valid_reg && m_status_reg != STATUS_OK,
        m_id_reg == '0 && m_dlc_reg == '0 && m_payload_reg == '0)
    `N2C_ASSERT_SAME(a_good_frame_full, aclk, aresetn,
        m_valid_reg && m_status_reg == STATUS_OK, m_dlc_reg == DLC_FRAME)
    `N2C_ASSERT_NEXT(a_sentence_cleared, aclk, aresetn,
        in_accept && s_sentence_end,
        char_index_reg == '0 && comma_count_reg == '0 && scaled_value_reg == '0)
    `N2C_ASSERT_NEXT(a_stalled_frame_kept, aclk, aresetn,
        p3_valid_reg && !out_ready, p3_valid_reg)

endmodule

`default_nettype wire
